// ===== hdl/feedx_pkg.sv =====
// ----------------------------------------------------------------------------
// Feed extractor package
// Shared constants and the frame summary type for the UDP feed extractor.
// ----------------------------------------------------------------------------
package feedx_pkg;

   localparam int POS_W = 14;
   localparam logic [POS_W-1:0] MAX_FRAME_BYTES = 14'd16383;

   localparam logic [15:0] TARGET_PORT_RESET = 16'd9000;
   localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
   localparam logic [7:0]  IP_PROTO_UDP      = 8'd17;

   // Byte offsets within the frame.
   localparam logic [POS_W-1:0] POS_ETHERTYPE = 14'd13;
   localparam logic [POS_W-1:0] POS_IP_PROTO  = 14'd23;
   localparam logic [POS_W-1:0] POS_DST_PORT  = 14'd37;
   localparam logic [POS_W-1:0] POS_KIND      = 14'd42;
   localparam logic [POS_W-1:0] POS_ORDER_LO  = 14'd43;
   localparam logic [POS_W-1:0] POS_ORDER_HI  = 14'd46;
   localparam logic [POS_W-1:0] POS_SIDE      = 14'd47;
   localparam logic [POS_W-1:0] POS_PRICE_LO  = 14'd48;
   localparam logic [POS_W-1:0] POS_PRICE_HI  = 14'd51;
   localparam logic [POS_W-1:0] POS_QTY_LO    = 14'd52;
   localparam logic [POS_W-1:0] POS_QTY_HI    = 14'd55;

   // Minimum frame lengths for each classification.
   localparam logic [POS_W-1:0] MIN_UDP_LEN  = 14'd34;
   localparam logic [POS_W-1:0] MIN_FEED_LEN = 14'd42;
   localparam logic [POS_W-1:0] MIN_FULL_LEN = 14'd64;

   // Summary of a frame as seen on its last byte.
   typedef struct packed {
      logic             is_udp;
      logic             is_feed;
      logic             is_full;
      logic [POS_W-1:0] frame_len;
      logic [7:0]       kind_code;
      logic [31:0]      order_ref;
      logic [7:0]       side_code;
      logic [31:0]      price;
      logic [31:0]      quantity;
   } frame_end_type;

endpackage

// ===== hdl/feedx_frame_parser.sv =====
// ----------------------------------------------------------------------------
// Feed extractor frame parser
// Tracks the byte position, header checks and captured message of a frame.
// ----------------------------------------------------------------------------
module feedx_frame_parser
   import feedx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          take,
   input  logic [7:0]    packet_byte,
   input  logic          last_byte,
   input  logic [15:0]   target_port,
   output frame_end_type frame_end
);

   logic [POS_W-1:0] pos_ff, pos_in, pos_adv;
   logic [15:0]      shift_ff, shift_in, shift_adv, shift_new;
   logic [2:0]       flags_ff, flags_in, flags_adv;
   logic [7:0]       kind_ff, kind_in, kind_adv;
   logic [31:0]      order_ff, order_in, order_adv;
   logic [7:0]       side_ff, side_in, side_adv;
   logic [31:0]      price_ff, price_in, price_adv;
   logic [31:0]      qty_ff, qty_in, qty_adv;
   logic             in_range;
   logic             udp_ok, feed_ok, full_ok;

   always_comb begin
      shift_new = {shift_ff[7:0], packet_byte};
      in_range  = (pos_ff < MAX_FRAME_BYTES);
      pos_adv   = pos_ff;
      shift_adv = shift_ff;
      flags_adv = flags_ff;
      kind_adv  = kind_ff;
      order_adv = order_ff;
      side_adv  = side_ff;
      price_adv = price_ff;
      qty_adv   = qty_ff;
      if (in_range) begin
         pos_adv   = pos_ff + 1'b1;
         shift_adv = shift_new;
         priority if (pos_ff == POS_ETHERTYPE && shift_new == ETHERTYPE_IPV4) begin
            flags_adv[0] = 1'b1;
         end else if (pos_ff == POS_IP_PROTO && flags_ff[0] && packet_byte == IP_PROTO_UDP) begin
            flags_adv[1] = 1'b1;
         end else if (pos_ff == POS_DST_PORT && flags_ff[1] && shift_new == target_port) begin
            flags_adv[2] = 1'b1;
         end else if (pos_ff == POS_KIND) begin
            kind_adv = packet_byte;
         end else if (pos_ff >= POS_ORDER_LO && pos_ff <= POS_ORDER_HI) begin
            order_adv = {order_ff[23:0], packet_byte};
         end else if (pos_ff == POS_SIDE) begin
            side_adv = packet_byte;
         end else if (pos_ff >= POS_PRICE_LO && pos_ff <= POS_PRICE_HI) begin
            price_adv = {price_ff[23:0], packet_byte};
         end else if (pos_ff >= POS_QTY_LO && pos_ff <= POS_QTY_HI) begin
            qty_adv = {qty_ff[23:0], packet_byte};
         end else begin
            // Any other byte only moves through the shift register.
         end
      end

      udp_ok  = flags_adv[1] && (pos_adv >= MIN_UDP_LEN);
      feed_ok = udp_ok && flags_adv[2] && (pos_adv >= MIN_FEED_LEN);
      full_ok = feed_ok && (pos_adv >= MIN_FULL_LEN);

      frame_end.is_udp    = udp_ok;
      frame_end.is_feed   = feed_ok;
      frame_end.is_full   = full_ok;
      frame_end.frame_len = pos_adv;
      frame_end.kind_code = full_ok ? kind_adv  : 8'd0;
      frame_end.order_ref = full_ok ? order_adv : 32'd0;
      frame_end.side_code = full_ok ? side_adv  : 8'd0;
      frame_end.price     = full_ok ? price_adv : 32'd0;
      frame_end.quantity  = full_ok ? qty_adv   : 32'd0;

      // Hold when idle, advance on a byte, and start over after the last byte.
      pos_in   = pos_ff;
      shift_in = shift_ff;
      flags_in = flags_ff;
      kind_in  = kind_ff;
      order_in = order_ff;
      side_in  = side_ff;
      price_in = price_ff;
      qty_in   = qty_ff;
      if (take) begin
         if (last_byte) begin
            pos_in   = '0;
            shift_in = '0;
            flags_in = '0;
            kind_in  = '0;
            order_in = '0;
            side_in  = '0;
            price_in = '0;
            qty_in   = '0;
         end else begin
            pos_in   = pos_adv;
            shift_in = shift_adv;
            flags_in = flags_adv;
            kind_in  = kind_adv;
            order_in = order_adv;
            side_in  = side_adv;
            price_in = price_adv;
            qty_in   = qty_adv;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         shift_ff <= '0;
         flags_ff <= '0;
         kind_ff  <= '0;
         order_ff <= '0;
         side_ff  <= '0;
         price_ff <= '0;
         qty_ff   <= '0;
      end else begin
         pos_ff   <= pos_in;
         shift_ff <= shift_in;
         flags_ff <= flags_in;
         kind_ff  <= kind_in;
         order_ff <= order_in;
         side_ff  <= side_in;
         price_ff <= price_in;
         qty_ff   <= qty_in;
      end
   end

endmodule

// ===== hdl/feedx_counters.sv =====
// ----------------------------------------------------------------------------
// Feed extractor statistics counters
// Four 64-bit wrapping counters updated at the end of each frame.
// ----------------------------------------------------------------------------
module feedx_counters
   import feedx_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          frame_done,
   input  frame_end_type frame_end,
   output logic [63:0]   udp_count_next,
   output logic [63:0]   feed_count_next,
   output logic [63:0]   byte_count_next,
   output logic [63:0]   drop_count_next
);

   logic [63:0] udp_ff, udp_in;
   logic [63:0] feed_ff, feed_in;
   logic [63:0] byte_ff, byte_in;
   logic [63:0] drop_ff, drop_in;

   always_comb begin
      udp_in  = udp_ff;
      feed_in = feed_ff;
      byte_in = byte_ff;
      drop_in = drop_ff;
      if (frame_done) begin
         if (frame_end.is_udp) begin
            udp_in = udp_ff + 64'd1;
         end
         if (frame_end.is_feed) begin
            feed_in = feed_ff + 64'd1;
         end
         if (frame_end.is_full) begin
            byte_in = byte_ff + {{(64-POS_W){1'b0}}, frame_end.frame_len};
         end
         if (frame_end.is_feed && !frame_end.is_full) begin
            drop_in = drop_ff + 64'd1;
         end
      end
   end

   assign udp_count_next  = udp_in;
   assign feed_count_next = feed_in;
   assign byte_count_next = byte_in;
   assign drop_count_next = drop_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         udp_ff  <= '0;
         feed_ff <= '0;
         byte_ff <= '0;
         drop_ff <= '0;
      end else begin
         udp_ff  <= udp_in;
         feed_ff <= feed_in;
         byte_ff <= byte_in;
         drop_ff <= drop_in;
      end
   end

endmodule

// ===== hdl/udp_feed_message_extractor_core.sv =====
// ----------------------------------------------------------------------------
// UDP feed message extractor
// Parses Ethernet/IPv4/UDP frames byte by byte and extracts feed messages.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the req_ channel, one byte per transaction, starting
// at the Ethernet destination address; req_last_byte marks the final byte and
// req_time_ns is sampled with it. Each frame produces exactly one transaction
// on the rsp_ channel, issued for its last byte, carrying the extracted
// message (valid when rsp_has_message is set), the timestamp and the four
// statistics counters as they stand after this frame.
// Timing: a byte is parsed while it sits in the input register; for a last
// byte the result is loaded into the output register once that register is
// free, and rsp_valid is driven from the output register. Throughput is one
// byte per cycle, but a last byte waits while a result is still pending.
// The UDP destination port of feed traffic is set through csr_wr_en and
// csr_wr_data and resets to 9000. Reset clears the frame state and the
// counters, restores the port to 9000 and empties both pipeline registers.
// When the receiver stalls, a pending result sits in the output register;
// bytes that are not a frame end keep flowing, and a last byte waits in the
// input register until the output register frees up.
// ----------------------------------------------------------------------------
module udp_feed_message_extractor_core
   import feedx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // Configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // Byte input channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_packet_byte,
   input  logic        req_last_byte,
   input  logic [63:0] req_time_ns,
   // Result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_message,
   output logic [7:0]  rsp_kind_code,
   output logic [31:0] rsp_order_ref,
   output logic [7:0]  rsp_side_code,
   output logic [31:0] rsp_price,
   output logic [31:0] rsp_quantity,
   output logic [63:0] rsp_stamp_ns,
   output logic [63:0] rsp_udp_packet_count,
   output logic [63:0] rsp_feed_packet_count,
   output logic [63:0] rsp_feed_byte_count,
   output logic [63:0] rsp_dropped_count
);

   // Feed port register.
   logic [15:0] target_port_ff, target_port_in;

   // Input register stage.
   logic        s1_valid_ff, s1_valid_in;
   logic [7:0]  s1_byte_ff;
   logic        s1_last_ff;
   logic [63:0] s1_time_ff;

   // Output register stage.
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_has_message_ff;
   logic [7:0]  rsp_kind_code_ff;
   logic [31:0] rsp_order_ref_ff;
   logic [7:0]  rsp_side_code_ff;
   logic [31:0] rsp_price_ff;
   logic [31:0] rsp_quantity_ff;
   logic [63:0] rsp_stamp_ns_ff;
   logic [63:0] rsp_udp_ff;
   logic [63:0] rsp_feed_ff;
   logic [63:0] rsp_byte_ff;
   logic [63:0] rsp_drop_ff;

   logic          req_fire;
   logic          out_free;
   logic          s1_fire;
   logic          frame_done;
   frame_end_type frame_end;
   logic [63:0]   udp_count_next;
   logic [63:0]   feed_count_next;
   logic [63:0]   byte_count_next;
   logic [63:0]   drop_count_next;

   // The output register can take a new result when it is empty or being
   // drained this cycle. Only a last byte needs room there; other bytes
   // leave the input register unconditionally.
   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign s1_fire    = s1_valid_ff && (!s1_last_ff || out_free);
   assign frame_done = s1_fire && s1_last_ff;
   assign req_ready  = !s1_valid_ff || s1_fire;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      target_port_in = csr_wr_en ? csr_wr_data : target_port_ff;

      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (frame_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   feedx_frame_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .take        (s1_fire),
      .packet_byte (s1_byte_ff),
      .last_byte   (s1_last_ff),
      .target_port (target_port_ff),
      .frame_end   (frame_end)
   );

   feedx_counters u_counters (
      .clock           (clock),
      .reset           (reset),
      .frame_done      (frame_done),
      .frame_end       (frame_end),
      .udp_count_next  (udp_count_next),
      .feed_count_next (feed_count_next),
      .byte_count_next (byte_count_next),
      .drop_count_next (drop_count_next)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         target_port_ff <= TARGET_PORT_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         target_port_ff <= target_port_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // Payload registers of both stages.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff <= req_packet_byte;
         s1_last_ff <= req_last_byte;
         s1_time_ff <= req_time_ns;
      end
      if (frame_done) begin
         rsp_has_message_ff <= frame_end.is_full;
         rsp_kind_code_ff   <= frame_end.kind_code;
         rsp_order_ref_ff   <= frame_end.order_ref;
         rsp_side_code_ff   <= frame_end.side_code;
         rsp_price_ff       <= frame_end.price;
         rsp_quantity_ff    <= frame_end.quantity;
         rsp_stamp_ns_ff    <= s1_time_ff;
         rsp_udp_ff         <= udp_count_next;
         rsp_feed_ff        <= feed_count_next;
         rsp_byte_ff        <= byte_count_next;
         rsp_drop_ff        <= drop_count_next;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_has_message       = rsp_has_message_ff;
   assign rsp_kind_code         = rsp_kind_code_ff;
   assign rsp_order_ref         = rsp_order_ref_ff;
   assign rsp_side_code         = rsp_side_code_ff;
   assign rsp_price             = rsp_price_ff;
   assign rsp_quantity          = rsp_quantity_ff;
   assign rsp_stamp_ns          = rsp_stamp_ns_ff;
   assign rsp_udp_packet_count  = rsp_udp_ff;
   assign rsp_feed_packet_count = rsp_feed_ff;
   assign rsp_feed_byte_count   = rsp_byte_ff;
   assign rsp_dropped_count     = rsp_drop_ff;

`ifndef NO_ASSERTIONS
   // A frame end always lands in the output register on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      frame_done |=> rsp_valid_ff)
      else $error("frame end did not produce a result");

   // The stamp of a result is the time value that came with the last byte.
   assert property (@(posedge clock) disable iff (reset)
      frame_done |=> (rsp_stamp_ns_ff == $past(s1_time_ff)))
      else $error("result stamp does not match last byte time");

   // A frame without a message reports zeroed message fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_message_ff) |->
         (rsp_kind_code_ff == 8'd0 && rsp_order_ref_ff == 32'd0 &&
          rsp_side_code_ff == 8'd0 && rsp_price_ff == 32'd0 &&
          rsp_quantity_ff == 32'd0))
      else $error("message fields not cleared without a message");

   // An empty input register never blocks the byte channel.
   assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff |-> req_ready)
      else $error("input stalled with empty input register");

   // A last byte never overwrites a result that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |-> !frame_done)
      else $error("pending result overwritten");
`endif

endmodule
